FILE: design/wavp_pkg.sv
// Shared types, tag constants and helper functions for the WAV header stream parser.
package wavp_pkg;

    // Little-endian tag words, first letter in the low byte
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int unsigned TDATA_W = 96;

    // Parser phases
    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_SCAN_FMT,
        PH_FSIZE,
        PH_FORMAT,
        PH_CHAN,
        PH_RATE,
        PH_SKIP6,
        PH_BITS,
        PH_SCAN_DATA,
        PH_DSIZE,
        PH_PAYLOAD,
        PH_IDLE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NOT_RIFF = 2'd0,
        ERR_NOT_WAVE = 2'd1,
        ERR_NOT_PCM  = 2'd2,
        ERR_TRUNC    = 2'd3
    } t_err;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  channel_count;
        logic [31:0] sample_rate;
        logic [7:0]  sample_bits;
        logic [31:0] payload_size;
        t_err        error_code;
        logic        last_of_data;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [1:0] count;
    } t_scan;

    // Running tag search: a mismatch restarts, the first letter restarts at one
    function automatic t_scan scan_tag(input logic [7:0] b, input logic [31:0] tag,
                                       input logic [1:0] count);
        logic [2:0] c;
        logic       hit;
        t_scan      s;
        c   = {1'b0, count};
        hit = 1'b0;
        if (c != 3'd0) begin
            if (b == tag[{count, 3'b000} +: 8]) begin
                c = c + 3'd1;
                if (c == 3'd4) begin
                    hit = 1'b1;
                    c   = 3'd0;
                end
            end else begin
                c = 3'd0;
            end
        end
        if (!hit && b == tag[7:0]) begin
            c = 3'd1;
        end
        s.hit   = hit;
        s.count = c[1:0];
        return s;
    endfunction

    // Pack a result into the output data bus, first field lowest
    function automatic logic [TDATA_W-1:0] pack_tdata(input t_result r);
        return {6'b0, r.error_code, r.payload_size, r.sample_bits, r.sample_rate,
                r.channel_count, r.data_byte};
    endfunction

endpackage

FILE: design/wav_header_stream_parser.sv
// A result is registered in the output register, or in the skid register under a stall.
// Throughput: one byte per cycle while the skid register is empty; a header result is
// followed directly by payload bytes; the result buffer has two entries.
// Reset (synchronous, active low) returns the parser to the RIFF tag check and
// empties the result buffer; a byte flagged as file start also restarts parsing.
module wav_header_stream_parser
    import wavp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
    input  logic               s_axis_tuser,   // [0] file_start
    input  logic               s_axis_tlast,   // stream_end
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [15:8] channel_count,
                                               // [47:16] sample_rate, [55:48] sample_bits,
                                               // [87:56] payload_size, [89:88] error_code
    output logic [1:0]         m_axis_tuser,   // [1:0] result_kind
    output logic               m_axis_tlast    // last_of_data
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    wavp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (s_axis_tdata),
        .i_file_start (s_axis_tuser),
        .i_stream_end (s_axis_tlast),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    wavp_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept && res_valid),
        .i_res    (res),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_res    (out_res),
        .i_ready  (m_axis_tready)
    );

    // Master-side packing
    assign m_axis_tdata = pack_tdata(out_res);
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_of_data;

endmodule

FILE: design/wavp_core.sv
// Parser state machine: one byte in per transfer, at most one result out.
module wavp_core
    import wavp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_file_start,
    input  logic       i_stream_end,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_asm, n_asm;
    logic [7:0]  r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [7:0]  r_bits, n_bits;
    logic [31:0] r_rem, n_rem;

    // State as seen by this byte (file start clears it first)
    t_phase      ph;
    logic [2:0]  pos;
    logic [1:0]  cnt;
    logic [31:0] asm_cur;
    logic [2:0]  pos_inc;
    logic [31:0] asm_new;
    logic [31:0] rem_dec;
    t_scan       scan_fmt, scan_data;
    logic        carried;
    logic [7:0]  keep_byte;

    always_comb begin
        ph      = i_file_start ? PH_RIFF : r_phase;
        pos     = i_file_start ? 3'd0 : r_pos;
        cnt     = i_file_start ? 2'd0 : r_cnt;
        asm_cur = i_file_start ? 32'd0 : r_asm;
        n_chan  = i_file_start ? 8'd0 : r_chan;
        n_rate  = i_file_start ? 32'd0 : r_rate;
        n_bits  = i_file_start ? 8'd0 : r_bits;
        n_rem   = i_file_start ? 32'd0 : r_rem;

        pos_inc = pos + 3'd1;
        asm_new = asm_cur;
        asm_new[{pos[1:0], 3'b000} +: 8] = asm_cur[{pos[1:0], 3'b000} +: 8] | i_byte;
        rem_dec   = (n_rem != 32'd0) ? n_rem - 32'd1 : n_rem;
        scan_fmt  = scan_tag(i_byte, TAG_FMT, cnt);
        scan_data = scan_tag(i_byte, TAG_DATA, cnt);

        n_phase     = ph;
        n_pos       = pos;
        n_cnt       = cnt;
        n_asm       = asm_cur;
        o_res_valid = 1'b0;
        o_res       = '0;

        // Per-phase byte handling; a phase change clears the field counters
        unique case (ph)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_FSIZE, PH_RATE, PH_DSIZE: begin
                n_pos = pos_inc;
                n_asm = asm_new;
                if (pos_inc >= 3'd4) begin
                    n_pos = 3'd0;
                    n_cnt = 2'd0;
                    n_asm = 32'd0;
                    case (ph)
                        PH_RIFF: begin
                            if (asm_new != TAG_RIFF) begin
                                o_res_valid      = 1'b1;
                                o_res.kind       = KIND_ERROR;
                                o_res.error_code = ERR_NOT_RIFF;
                                n_phase          = PH_IDLE;
                            end else begin
                                n_phase = PH_RSIZE;
                            end
                        end
                        PH_RSIZE: n_phase = PH_WAVE;
                        PH_WAVE: begin
                            if (asm_new != TAG_WAVE) begin
                                o_res_valid      = 1'b1;
                                o_res.kind       = KIND_ERROR;
                                o_res.error_code = ERR_NOT_WAVE;
                                n_phase          = PH_IDLE;
                            end else begin
                                n_phase = PH_SCAN_FMT;
                            end
                        end
                        PH_FSIZE: n_phase = PH_FORMAT;
                        PH_RATE: begin
                            n_rate  = asm_new;
                            n_phase = PH_SKIP6;
                        end
                        default: begin
                            // data chunk size complete: emit the header
                            n_rem               = asm_new;
                            o_res_valid         = 1'b1;
                            o_res.kind          = KIND_HEADER;
                            o_res.channel_count = n_chan;
                            o_res.sample_rate   = n_rate;
                            o_res.sample_bits   = n_bits;
                            o_res.payload_size  = asm_new;
                            o_res.last_of_data  = (asm_new == 32'd0);
                            n_phase = (asm_new == 32'd0) ? PH_IDLE : PH_PAYLOAD;
                        end
                    endcase
                end
            end
            PH_FORMAT, PH_CHAN, PH_BITS: begin
                n_pos = pos_inc;
                n_asm = asm_new;
                if (pos_inc >= 3'd2) begin
                    n_pos = 3'd0;
                    n_cnt = 2'd0;
                    n_asm = 32'd0;
                    case (ph)
                        PH_FORMAT: begin
                            if (asm_new != 32'd1) begin
                                o_res_valid      = 1'b1;
                                o_res.kind       = KIND_ERROR;
                                o_res.error_code = ERR_NOT_PCM;
                                n_phase          = PH_IDLE;
                            end else begin
                                n_phase = PH_CHAN;
                            end
                        end
                        PH_CHAN: begin
                            n_chan  = asm_new[7:0];
                            n_phase = PH_RATE;
                        end
                        default: begin
                            n_bits  = asm_new[7:0];
                            n_phase = PH_SCAN_DATA;
                        end
                    endcase
                end
            end
            PH_SKIP6: begin
                n_pos = pos_inc;
                if (pos_inc >= 3'd6) begin
                    n_phase = PH_BITS;
                    n_pos   = 3'd0;
                    n_cnt   = 2'd0;
                    n_asm   = 32'd0;
                end
            end
            PH_SCAN_FMT: begin
                n_cnt = scan_fmt.count;
                if (scan_fmt.hit) begin
                    n_phase = PH_FSIZE;
                    n_pos   = 3'd0;
                    n_cnt   = 2'd0;
                    n_asm   = 32'd0;
                end
            end
            PH_SCAN_DATA: begin
                n_cnt = scan_data.count;
                if (scan_data.hit) begin
                    n_phase = PH_DSIZE;
                    n_pos   = 3'd0;
                    n_cnt   = 2'd0;
                    n_asm   = 32'd0;
                end
            end
            PH_PAYLOAD: begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_PAYLOAD;
                o_res.data_byte = i_byte;
                n_rem           = rem_dec;
                if (rem_dec == 32'd0) begin
                    o_res.last_of_data = 1'b1;
                    n_phase = PH_IDLE;
                    n_pos   = 3'd0;
                    n_cnt   = 2'd0;
                    n_asm   = 32'd0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Early end of file overrides this byte's result
        carried   = o_res_valid && (o_res.kind == KIND_PAYLOAD);
        keep_byte = carried ? i_byte : 8'd0;
        if (i_stream_end && n_phase != PH_IDLE) begin
            o_res_valid      = 1'b1;
            o_res            = '0;
            o_res.kind       = KIND_ERROR;
            o_res.data_byte  = keep_byte;
            o_res.error_code = ERR_TRUNC;
            n_rem   = 32'd0;
            n_phase = PH_IDLE;
            n_pos   = 3'd0;
            n_cnt   = 2'd0;
            n_asm   = 32'd0;
        end
    end

    // State registers, advanced once per accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_pos   <= 3'd0;
            r_cnt   <= 2'd0;
            r_asm   <= 32'd0;
            r_chan  <= 8'd0;
            r_rate  <= 32'd0;
            r_bits  <= 8'd0;
            r_rem   <= 32'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_asm   <= n_asm;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_rem   <= n_rem;
        end
    end

endmodule

FILE: design/wavp_skid.sv
// Result register with a skid stage so input keeps flowing while output stalls, until the skid stage holds a result.
module wavp_skid
    import wavp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

FILE: design/wavp_checker.sv
// Port-level checks for the WAV header stream parser, bound to the top level.
module wavp_checker
    import wavp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]         m_axis_tuser,
    input logic               m_axis_tlast
);

    // Output is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Only payload, header and error kinds exist
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("illegal result kind");

    // A header is marked last exactly when its payload size is zero
    a_header_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_HEADER |->
            m_axis_tlast == (m_axis_tdata[87:56] == 32'd0))
        else $error("header last flag disagrees with size");

    // Non-error results carry a zero error code and no stray padding
    a_err_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_ERROR |-> m_axis_tdata[95:88] == 8'd0)
        else $error("error code set on a non-error result");

endmodule

bind wav_header_stream_parser wavp_checker u_wavp_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench for the streaming WAV header parser: directed rows, then random files.
`timescale 1ns / 1ps

module tb_top;
    import wavp_pkg::*;

    localparam int TARGET_BYTES = 750;
    localparam int N_DIR        = 21;
    localparam int MAX_REPORTS  = 20;

    // Kinds of generated files
    typedef enum {
        F_GOOD,
        F_EMPTY,
        F_NON_PCM,
        F_BAD_RIFF,
        F_BAD_WAVE,
        F_TRUNC,
        F_HDR_TRUNC,
        F_RESTART,
        F_BIG
    } t_file_kind;

    // Directed row: byte, flags, and an error result typed in where one is certain
    typedef struct packed {
        logic [7:0] b;
        logic       fs;
        logic       se;
        logic       typed;
        t_err       code;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic               s_axis_tuser  = 1'b0;    // [0] file_start
    logic               s_axis_tlast  = 1'b0;    // stream_end
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;            // [7:0] data_byte, [15:8] channel_count,
                                                 // [47:16] sample_rate, [55:48] sample_bits,
                                                 // [87:56] payload_size, [89:88] error_code
    logic [1:0]         m_axis_tuser;            // [1:0] result_kind
    logic               m_axis_tlast;            // last_of_data

    // Parser mirror state
    t_phase      ph;
    logic [2:0]  byte_idx;
    logic [2:0]  tag_hits;
    logic [31:0] word_acc;
    logic [7:0]  hdr_chans;
    logic [31:0] hdr_rate;
    logic [7:0]  hdr_bits;
    logic [31:0] bytes_left;

    t_result     parsed_q[$];
    logic [7:0]  file_img[$];
    t_dir_row    dir_rows [0:N_DIR-1];

    bit calm;
    int fail_count   = 0;
    int active_items = 0;
    int n_headers    = 0;
    int n_payload    = 0;
    int n_errors     = 0;

    wav_header_stream_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("[wav_header_stream_parser] ERROR");
        $finish;
    end

    // ---------------- parser mirror ----------------

    function automatic void enter_phase(input t_phase p);
        ph       = p;
        byte_idx = 3'd0;
        tag_hits = 3'd0;
        word_acc = 32'd0;
    endfunction

    function automatic void clear_parser();
        enter_phase(PH_RIFF);
        hdr_chans  = 8'd0;
        hdr_rate   = 32'd0;
        hdr_bits   = 8'd0;
        bytes_left = 32'd0;
    endfunction

    // Little-endian field assembly; true once len bytes are in
    function automatic bit take_le(input logic [7:0] b, input int unsigned len);
        word_acc = word_acc | (32'(b) << (8 * byte_idx[1:0]));
        byte_idx = byte_idx + 3'd1;
        return byte_idx >= len;
    endfunction

    // Running tag search; a miss restarts, the first letter restarts at one
    function automatic bit hunt_tag(input logic [7:0] b, input logic [31:0] tag);
        logic [2:0] c;
        c = tag_hits;
        if (c != 3'd0) begin
            if (c < 3'd4 && b == tag[{c[1:0], 3'b000} +: 8])
                c = c + 3'd1;
            else
                c = 3'd0;
        end
        if (c == 3'd4) begin
            tag_hits = 3'd0;
            return 1'b1;
        end
        if (b == tag[7:0])
            c = 3'd1;
        tag_hits = c;
        return 1'b0;
    endfunction

    task automatic parse_wav_byte(input logic [7:0] b, input logic fs, input logic se,
                                  output bit got, output t_result r);
        logic [7:0] keep;
        got = 1'b0;
        r   = '0;
        if (fs)
            clear_parser();

        case (ph)
            PH_RIFF: begin
                if (take_le(b, 4)) begin
                    if (word_acc != TAG_RIFF) begin
                        got          = 1'b1;
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_NOT_RIFF;
                        enter_phase(PH_IDLE);
                    end else begin
                        enter_phase(PH_RSIZE);
                    end
                end
            end
            PH_RSIZE: begin
                if (take_le(b, 4))
                    enter_phase(PH_WAVE);
            end
            PH_WAVE: begin
                if (take_le(b, 4)) begin
                    if (word_acc != TAG_WAVE) begin
                        got          = 1'b1;
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_NOT_WAVE;
                        enter_phase(PH_IDLE);
                    end else begin
                        enter_phase(PH_SCAN_FMT);
                    end
                end
            end
            PH_SCAN_FMT: begin
                if (hunt_tag(b, TAG_FMT))
                    enter_phase(PH_FSIZE);
            end
            PH_FSIZE: begin
                if (take_le(b, 4))
                    enter_phase(PH_FORMAT);
            end
            PH_FORMAT: begin
                if (take_le(b, 2)) begin
                    if (word_acc != 32'd1) begin
                        got          = 1'b1;
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_NOT_PCM;
                        enter_phase(PH_IDLE);
                    end else begin
                        enter_phase(PH_CHAN);
                    end
                end
            end
            PH_CHAN: begin
                if (take_le(b, 2)) begin
                    hdr_chans = word_acc[7:0];
                    enter_phase(PH_RATE);
                end
            end
            PH_RATE: begin
                if (take_le(b, 4)) begin
                    hdr_rate = word_acc;
                    enter_phase(PH_SKIP6);
                end
            end
            PH_SKIP6: begin
                // byte rate and block align are not kept
                byte_idx = byte_idx + 3'd1;
                if (byte_idx >= 3'd6)
                    enter_phase(PH_BITS);
            end
            PH_BITS: begin
                if (take_le(b, 2)) begin
                    hdr_bits = word_acc[7:0];
                    enter_phase(PH_SCAN_DATA);
                end
            end
            PH_SCAN_DATA: begin
                if (hunt_tag(b, TAG_DATA))
                    enter_phase(PH_DSIZE);
            end
            PH_DSIZE: begin
                if (take_le(b, 4)) begin
                    bytes_left      = word_acc;
                    got             = 1'b1;
                    r.kind          = KIND_HEADER;
                    r.channel_count = hdr_chans;
                    r.sample_rate   = hdr_rate;
                    r.sample_bits   = hdr_bits;
                    r.payload_size  = bytes_left;
                    r.last_of_data  = (bytes_left == 32'd0);
                    enter_phase(bytes_left == 32'd0 ? PH_IDLE : PH_PAYLOAD);
                end
            end
            PH_PAYLOAD: begin
                got         = 1'b1;
                r.kind      = KIND_PAYLOAD;
                r.data_byte = b;
                if (bytes_left != 32'd0)
                    bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0) begin
                    r.last_of_data = 1'b1;
                    enter_phase(PH_IDLE);
                end
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase

        // Early end replaces this byte's result; a payload byte rides along
        if (se && ph != PH_IDLE) begin
            keep         = (got && r.kind == KIND_PAYLOAD) ? r.data_byte : 8'h00;
            r            = '0;
            r.kind       = KIND_ERROR;
            r.data_byte  = keep;
            r.error_code = ERR_TRUNC;
            got          = 1'b1;
            bytes_left   = 32'd0;
            enter_phase(PH_IDLE);
        end
    endtask

    // ---------------- stimulus ----------------

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // One byte transfer on the slave side, then the mirror is stepped
    task automatic send_byte(input logic [7:0] b, input logic fs, input logic se,
                             input logic typed, input t_err code);
        int      gap;
        bit      got;
        t_result r;
        t_result typed_r;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= fs;
        s_axis_tlast  <= se;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);

        if (fs || ph != PH_IDLE)
            active_items++;
        parse_wav_byte(b, fs, se, got, r);
        if (typed) begin
            typed_r            = '0;
            typed_r.kind       = KIND_ERROR;
            typed_r.error_code = code;
            parsed_q.push_back(typed_r);
        end else if (got) begin
            parsed_q.push_back(r);
        end
    endtask

    function automatic void add_word(input logic [31:0] w, input int n);
        for (int k = 0; k < n; k++)
            file_img.push_back(w[8*k +: 8]);
    endfunction

    // Scan noise: stray letters of the tag being searched, and random bytes
    function automatic void add_noise(input logic [31:0] tag);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
                0:       file_img.push_back(tag[7:0]);
                1:       file_img.push_back(tag[15:8]);
                2:       file_img.push_back(tag[23:16]);
                default: file_img.push_back(8'($urandom));
            endcase
        end
    endfunction

    task automatic send_file(input t_file_kind kind);
        logic [31:0] size;
        logic [31:0] rate;
        logic [31:0] fmt_code;
        int          hdr_end;
        int          stop_at;
        int          n_pay;
        int          n_tail;
        bit          end_flag;

        file_img.delete();
        add_word(TAG_RIFF, 4);
        if (kind == F_BAD_RIFF)
            file_img[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
        add_word($urandom, 4);
        add_word(TAG_WAVE, 4);
        if (kind == F_BAD_WAVE)
            file_img[8 + $urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
        add_noise(TAG_FMT);
        add_word(TAG_FMT, 4);
        add_word($urandom, 4);

        fmt_code = 32'd1;
        if (kind == F_NON_PCM) begin
            case ($urandom_range(0, 3))
                0:       fmt_code = 32'h0000;
                1:       fmt_code = 32'h0003;
                2:       fmt_code = 32'hFFFF;
                default: fmt_code = 32'h0100;
            endcase
        end
        add_word(fmt_code, 2);
        add_word($urandom, 2);                     // channels
        case ($urandom_range(0, 2))
            0:       rate = 32'd44100;
            1:       rate = 32'd48000;
            default: rate = $urandom;
        endcase
        add_word(rate, 4);
        add_word($urandom, 4);                     // byte rate
        add_word($urandom, 2);                     // block align
        add_word($urandom, 2);                     // bits per sample
        add_noise(TAG_DATA);
        add_word(TAG_DATA, 4);

        if (kind == F_BIG)
            size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h0000_0100);
        else if (kind == F_EMPTY)
            size = 32'd0;
        else if (kind == F_HDR_TRUNC || $urandom_range(0, 3) != 0)
            size = $urandom_range(1, 24);
        else
            size = 32'd0;
        add_word(size, 4);
        hdr_end = file_img.size() - 1;
        n_pay   = (kind == F_BIG) ? $urandom_range(1, 8) : int'(size);
        repeat (n_pay) file_img.push_back(8'($urandom));

        // Where the file stops and whether its last byte carries stream end
        stop_at  = file_img.size() - 1;
        end_flag = $urandom_range(0, 1);
        n_tail   = $urandom_range(0, 3);
        case (kind)
            F_TRUNC: begin
                stop_at  = $urandom_range(0, file_img.size() - 1);
                end_flag = 1'b1;
            end
            F_HDR_TRUNC: begin
                stop_at  = hdr_end;
                end_flag = 1'b1;
            end
            F_RESTART: begin
                stop_at  = $urandom_range(0, file_img.size() - 2);
                end_flag = 1'b0;
                n_tail   = 0;
            end
            F_BIG: begin
                n_tail = 0;
            end
            default: ;
        endcase

        for (int k = 0; k <= stop_at; k++)
            send_byte(file_img[k], k == 0, end_flag && k == stop_at, 1'b0, ERR_NOT_RIFF);
        // trailing bytes after the end are ignored by the block
        for (int k = 0; k < n_tail; k++)
            send_byte(8'($urandom), 1'b0, 1'(($urandom_range(0, 1))), 1'b0, ERR_NOT_RIFF);
    endtask

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    initial begin
        int      stall_left;
        t_result want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (parsed_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with none expected, got kind %0d tdata %h",
                                 $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = parsed_q.pop_front();
                    check_field("result_kind",   want.kind,          m_axis_tuser);
                    check_field("data_byte",     want.data_byte,     m_axis_tdata[7:0]);
                    check_field("channel_count", want.channel_count, m_axis_tdata[15:8]);
                    check_field("sample_rate",   want.sample_rate,   m_axis_tdata[47:16]);
                    check_field("sample_bits",   want.sample_bits,   m_axis_tdata[55:48]);
                    check_field("payload_size",  want.payload_size,  m_axis_tdata[87:56]);
                    check_field("error_code",    want.error_code,    m_axis_tdata[89:88]);
                    check_field("last_of_data",  want.last_of_data,  m_axis_tlast);
                    case (want.kind)
                        KIND_HEADER:  n_headers++;
                        KIND_PAYLOAD: n_payload++;
                        default:      n_errors++;
                    endcase
                end
            end
            // Receiver stalls
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = idle_len();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        int         file_no;
        t_file_kind kind;

        dir_rows = '{
            {8'hFF, 1'b1, 1'b0, 1'b0, ERR_NOT_RIFF},   // extreme bytes as the RIFF tag
            {8'h00, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'hFF, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h00, 1'b0, 1'b0, 1'b1, ERR_NOT_RIFF},
            {8'h00, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},   // ignored after error
            {8'h52, 1'b1, 1'b0, 1'b0, ERR_NOT_RIFF},   // early end inside the tag
            {8'h49, 1'b0, 1'b1, 1'b1, ERR_TRUNC},
            {8'h52, 1'b1, 1'b0, 1'b0, ERR_NOT_RIFF},   // good RIFF, bad WAVE
            {8'h49, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h46, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h46, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'hFF, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h00, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'hFF, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h00, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h57, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h41, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h56, 1'b0, 1'b0, 1'b0, ERR_NOT_RIFF},
            {8'h58, 1'b0, 1'b0, 1'b1, ERR_NOT_WAVE},
            {8'hFF, 1'b0, 1'b1, 1'b0, ERR_NOT_RIFF},   // stream end while idle
            {8'h52, 1'b1, 1'b1, 1'b1, ERR_TRUNC}       // restart and end on one byte
        };

        calm = 1'b0;
        clear_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        for (int i = 0; i < N_DIR; i++)
            send_byte(dir_rows[i].b, dir_rows[i].fs, dir_rows[i].se,
                      dir_rows[i].typed, dir_rows[i].code);

        // Random files; the first eight cover each kind but F_GOOD once
        file_no = 0;
        while (active_items < TARGET_BYTES) begin
            calm = ($urandom_range(0, 3) == 0);
            case (file_no)
                0: kind = F_EMPTY;
                1: kind = F_NON_PCM;
                2: kind = F_HDR_TRUNC;
                3: kind = F_BIG;
                4: kind = F_TRUNC;
                5: kind = F_RESTART;
                6: kind = F_BAD_RIFF;
                7: kind = F_BAD_WAVE;
                default: begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: kind = F_GOOD;
                        10:      kind = F_NON_PCM;
                        11:      kind = F_BAD_RIFF;
                        12:      kind = F_BAD_WAVE;
                        13, 14:  kind = F_TRUNC;
                        15:      kind = F_HDR_TRUNC;
                        16, 17:  kind = F_RESTART;
                        default: kind = F_BIG;
                    endcase
                end
            endcase
            send_file(kind);
            // Sender holds off until the output side has drained
            if (file_no == 2 || $urandom_range(0, 5) == 0) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (parsed_q.size() != 0) @(posedge i_clk);
            end
            file_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (parsed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d parsed bytes over %0d random files plus directed rows;",
                 active_items, file_no);
        $display("checked %0d headers, %0d payload bytes and %0d error results.",
                 n_headers, n_payload, n_errors);
        if (fail_count == 0)
            $display("[wav_header_stream_parser] OK");
        else
            $display("[wav_header_stream_parser] ERROR");
        $finish;
    end

endmodule
